@@ rtl/core/assert_macros.svh @@
// Assertion helpers; the including module provides clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition implies another on the same edge.
`define ASSERT_IMPL(lbl, pre, post, msg) \
	`ASSERT_AT(lbl, (pre) |-> (post), msg)

`endif

@@ rtl/core/pvl_pkg.sv @@
package pvl_pkg;

	localparam int FW        = 24;          // Q12.12 field width
	localparam int VW        = 26;          // signed vector component into the normalizer
	localparam int AW        = 25;          // magnitude of a component
	localparam int SHW       = 5;           // normalizing shift amount
	localparam int SQW       = 2 * AW;      // one square
	localparam int SW        = SQW + 2;     // sum of three squares
	localparam int MW        = 26;          // square root result
	localparam int DW        = 41;          // divider dividend and remainder
	localparam int QW        = 16;          // Q1.14 result
	localparam int SQ_STEPS  = 26;
	localparam int DIV_STEPS = QW;
	localparam int PW        = 40;          // normal times diffuse

	localparam int NORM_LAT  = 4 + SQ_STEPS + 1 + DIV_STEPS + 1;
	localparam int DOT_LAT   = 3;
	localparam int REFL_LAT  = 2;
	localparam int DLY_NL    = NORM_LAT + DOT_LAT;
	localparam int DLY_C     = NORM_LAT + DOT_LAT + REFL_LAT;
	localparam int DLY_DIF   = REFL_LAT + NORM_LAT + DOT_LAT;
	localparam int DLY_END   = 2 * (NORM_LAT + DOT_LAT) + REFL_LAT;

	localparam int UNIT_Q14  = 16384;
	localparam int HALF_Q14  = 8192;

	localparam int CIW = 2;
	localparam logic [CIW-1:0] REG_LIGHT_X = 2'd0;
	localparam logic [CIW-1:0] REG_LIGHT_Y = 2'd1;
	localparam logic [CIW-1:0] REG_LIGHT_Z = 2'd2;

	localparam logic signed [FW-1:0] LIGHT_X_RST = 24'sd0;
	localparam logic signed [FW-1:0] LIGHT_Y_RST = 24'sd0;
	localparam logic signed [FW-1:0] LIGHT_Z_RST = 24'sd4096;

	typedef logic signed [FW-1:0] fld_t;
	typedef logic signed [VW-1:0] vin_t;
	typedef logic signed [QW-1:0] q14_t;

	// trial bit of square root step k, starting at 2^50
	function automatic logic [SW-1:0] sq_bit(input int k);
		return SW'(1) << (SW - 2 - 2 * k);
	endfunction

endpackage

@@ rtl/core/pvl_if.sv @@
interface pvl_vtx_if;
	import pvl_pkg::*;
	logic valid;
	logic ready;
	fld_t normal_x;
	fld_t normal_y;
	fld_t normal_z;
	fld_t center_x;
	fld_t center_y;
	fld_t center_z;
	logic end_of_mesh;
	modport source (output valid, normal_x, normal_y, normal_z, center_x, center_y,
		center_z, end_of_mesh, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, center_x, center_y,
		center_z, end_of_mesh, output ready);
endinterface

interface pvl_res_if;
	import pvl_pkg::*;
	logic valid;
	logic ready;
	q14_t diffuse_term;
	q14_t specular_term;
	logic mesh_done;
	modport source (output valid, diffuse_term, specular_term, mesh_done, input ready);
	modport sink (input valid, diffuse_term, specular_term, mesh_done, output ready);
endinterface

interface pvl_cfg_if;
	import pvl_pkg::*;
	logic valid;
	logic ready;
	logic [CIW-1:0] index;
	logic [FW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/pvl_norm.sv @@
module pvl_norm (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  pvl_pkg::vin_t vin [3],
	output logic          out_valid,
	output pvl_pkg::q14_t u [3]
);
	import pvl_pkg::*;

	`include "assert_macros.svh"

	// stage 1: magnitudes and largest one
	logic [AW-1:0] a_s1 [3];
	logic [2:0]    neg_s1;
	logic [AW-1:0] max_s1;
	logic          v_s1;
	// stage 2: scaled so the largest lies in [2^24, 2^25)
	logic [AW-1:0] ash_s2 [3];
	logic [2:0]    neg_s2;
	logic          zero_s2;
	logic          v_s2;
	// stage 3: squares
	logic [SQW-1:0] sq_s3 [3];
	logic [AW-1:0]  ash_s3 [3];
	logic [2:0]     neg_s3;
	logic           zero_s3;
	logic           v_s3;
	// stage 4: sum of squares
	logic [SW-1:0] sum_s4;
	logic [AW-1:0] ash_s4 [3];
	logic [2:0]    neg_s4;
	logic          zero_s4;
	logic          v_s4;
	// square root, one result bit per stage
	logic [SW-1:0] rem_sq  [SQ_STEPS];
	logic [SW-1:0] root_sq [SQ_STEPS];
	logic [AW-1:0] ash_sq  [SQ_STEPS][3];
	logic [2:0]    neg_sq  [SQ_STEPS];
	logic          zero_sq [SQ_STEPS];
	logic          v_sq    [SQ_STEPS];
	// stage 5: rounded dividends
	logic [DW-1:0] num_s5 [3];
	logic [MW-1:0] mag_s5;
	logic [2:0]    neg_s5;
	logic          zero_s5;
	logic          v_s5;
	// divider, one quotient bit per stage
	logic [DW-1:0] rem_dv  [DIV_STEPS][3];
	logic [QW-1:0] quo_dv  [DIV_STEPS][3];
	logic [MW-1:0] mag_dv  [DIV_STEPS];
	logic [2:0]    neg_dv  [DIV_STEPS];
	logic          zero_dv [DIV_STEPS];
	logic          v_dv    [DIV_STEPS];
	// stage 6: cap and sign
	q14_t u_s6 [3];
	logic v_s6;

	logic [AW-1:0] a_c [3];
	logic [AW-1:0] max_c;
	logic [SHW-1:0] sh_c;
	logic [SW-1:0] sq_rem_in  [SQ_STEPS];
	logic [SW-1:0] sq_root_in [SQ_STEPS];
	logic [SW-1:0] sq_t       [SQ_STEPS];
	logic [SW-1:0] sq_rem_nx  [SQ_STEPS];
	logic [SW-1:0] sq_root_nx [SQ_STEPS];
	logic [MW-1:0] mag_c;
	logic [DW-1:0] dv_rem_in [DIV_STEPS][3];
	logic [QW-1:0] dv_quo_in [DIV_STEPS][3];
	logic [MW-1:0] dv_mag_in [DIV_STEPS];
	logic [DW-1:0] dv_rem_nx [DIV_STEPS][3];
	logic [QW-1:0] dv_quo_nx [DIV_STEPS][3];
	logic [QW-1:0] cap_c [3];

	always_comb begin
		logic [VW-1:0] t;
		for (int i = 0; i < 3; i++) begin
			t = vin[i][VW-1] ? (~vin[i] + 1'b1) : vin[i];
			a_c[i] = t[AW-1:0];
		end
		max_c = a_c[0];
		if (a_c[1] > max_c) max_c = a_c[1];
		if (a_c[2] > max_c) max_c = a_c[2];
	end

	always_comb begin
		sh_c = '0;
		for (int i = 0; i < AW; i++) begin
			if (max_s1[i]) sh_c = SHW'(AW - 1 - i);
		end
	end

	always_comb begin
		for (int k = 0; k < SQ_STEPS; k++) begin
			sq_rem_in[k]  = (k == 0) ? sum_s4 : rem_sq[k-1];
			sq_root_in[k] = (k == 0) ? '0 : root_sq[k-1];
			sq_t[k] = sq_root_in[k] + sq_bit(k);
			if (sq_rem_in[k] >= sq_t[k]) begin
				sq_rem_nx[k]  = sq_rem_in[k] - sq_t[k];
				sq_root_nx[k] = (sq_root_in[k] >> 1) + sq_bit(k);
			end else begin
				sq_rem_nx[k]  = sq_rem_in[k];
				sq_root_nx[k] = sq_root_in[k] >> 1;
			end
		end
	end

	assign mag_c = root_sq[SQ_STEPS-1][MW-1:0];

	always_comb begin
		logic [DW-1:0] d;
		for (int k = 0; k < DIV_STEPS; k++) begin
			dv_mag_in[k] = (k == 0) ? mag_s5 : mag_dv[k-1];
			d = DW'(dv_mag_in[k]) << (DIV_STEPS - 1 - k);
			for (int i = 0; i < 3; i++) begin
				dv_rem_in[k][i] = (k == 0) ? num_s5[i] : rem_dv[k-1][i];
				dv_quo_in[k][i] = (k == 0) ? '0 : quo_dv[k-1][i];
				if (dv_rem_in[k][i] >= d) begin
					dv_rem_nx[k][i] = dv_rem_in[k][i] - d;
					dv_quo_nx[k][i] = {dv_quo_in[k][i][QW-2:0], 1'b1};
				end else begin
					dv_rem_nx[k][i] = dv_rem_in[k][i];
					dv_quo_nx[k][i] = {dv_quo_in[k][i][QW-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cap_c[i] = quo_dv[DIV_STEPS-1][i];
			if (cap_c[i] > QW'(UNIT_Q14)) cap_c[i] = QW'(UNIT_Q14);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int k = 0; k < SQ_STEPS; k++) v_sq[k] <= 1'b0;
			for (int k = 0; k < DIV_STEPS; k++) v_dv[k] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			for (int k = 0; k < SQ_STEPS; k++) v_sq[k] <= (k == 0) ? v_s4 : v_sq[k-1];
			v_s5 <= v_sq[SQ_STEPS-1];
			for (int k = 0; k < DIV_STEPS; k++) v_dv[k] <= (k == 0) ? v_s5 : v_dv[k-1];
			v_s6 <= v_dv[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i]   <= a_c[i];
				neg_s1[i] <= vin[i][VW-1];
				ash_s2[i] <= a_s1[i] << sh_c;
				sq_s3[i]  <= ash_s2[i] * ash_s2[i];
				ash_s3[i] <= ash_s2[i];
				ash_s4[i] <= ash_s3[i];
			end
			max_s1  <= max_c;
			neg_s2  <= neg_s1;
			zero_s2 <= (max_s1 == '0);
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			sum_s4  <= SW'(sq_s3[0]) + SW'(sq_s3[1]) + SW'(sq_s3[2]);
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
			for (int k = 0; k < SQ_STEPS; k++) begin
				rem_sq[k]  <= sq_rem_nx[k];
				root_sq[k] <= sq_root_nx[k];
				for (int i = 0; i < 3; i++)
					ash_sq[k][i] <= (k == 0) ? ash_s4[i] : ash_sq[k-1][i];
				neg_sq[k]  <= (k == 0) ? neg_s4 : neg_sq[k-1];
				zero_sq[k] <= (k == 0) ? zero_s4 : zero_sq[k-1];
			end
			for (int i = 0; i < 3; i++)
				num_s5[i] <= (DW'(ash_sq[SQ_STEPS-1][i]) << 14) + DW'(mag_c >> 1);
			mag_s5  <= mag_c;
			neg_s5  <= neg_sq[SQ_STEPS-1];
			zero_s5 <= zero_sq[SQ_STEPS-1];
			for (int k = 0; k < DIV_STEPS; k++) begin
				for (int i = 0; i < 3; i++) begin
					rem_dv[k][i] <= dv_rem_nx[k][i];
					quo_dv[k][i] <= dv_quo_nx[k][i];
				end
				mag_dv[k]  <= dv_mag_in[k];
				neg_dv[k]  <= (k == 0) ? neg_s5 : neg_dv[k-1];
				zero_dv[k] <= (k == 0) ? zero_s5 : zero_dv[k-1];
			end
			for (int i = 0; i < 3; i++) begin
				if (zero_dv[DIV_STEPS-1])
					u_s6[i] <= '0;
				else if (neg_dv[DIV_STEPS-1][i])
					u_s6[i] <= -$signed(cap_c[i]);
				else
					u_s6[i] <= $signed(cap_c[i]);
			end
		end
	end

	assign out_valid = v_s6;
	assign u = u_s6;

	`ASSERT_IMPL(a_mag_range, v_s5 && !zero_s5, mag_s5 >= MW'(1 << 24),
		"magnitude of a scaled nonzero vector below 2^24")
	`ASSERT_IMPL(a_unit_len, v_s6 && (u_s6[0] != 0 || u_s6[1] != 0 || u_s6[2] != 0),
		u_s6[0] >= 9000 || u_s6[0] <= -9000 || u_s6[1] >= 9000 || u_s6[1] <= -9000 ||
		u_s6[2] >= 9000 || u_s6[2] <= -9000,
		"normalized vector far from unit length")

endmodule

@@ rtl/core/pvl_dot.sv @@
module pvl_dot (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  pvl_pkg::q14_t a [3],
	input  pvl_pkg::q14_t b [3],
	output logic          out_valid,
	output pvl_pkg::q14_t dot
);
	import pvl_pkg::*;

	`include "assert_macros.svh"

	logic signed [31:0] p_s1 [3];
	logic               v_s1;
	logic signed [31:0] sum_s2;
	logic               v_s2;
	q14_t               dot_s3;
	logic               v_s3;

	logic [31:0] mag_c;
	logic [17:0] rnd_c;

	always_comb begin
		mag_c = sum_s2[31] ? (~sum_s2 + 1'b1) : sum_s2;
		rnd_c = 18'((mag_c + 32'(HALF_Q14)) >> 14);
		if (rnd_c > 18'(UNIT_Q14)) rnd_c = 18'(UNIT_Q14);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) p_s1[i] <= a[i] * b[i];
			sum_s2 <= p_s1[0] + p_s1[1] + p_s1[2];
			// round halves away from zero
			dot_s3 <= sum_s2[31] ? -$signed(rnd_c[QW-1:0]) : $signed(rnd_c[QW-1:0]);
		end
	end

	assign out_valid = v_s3;
	assign dot = dot_s3;

	`ASSERT_IMPL(a_dot_range, v_s3, dot_s3 <= UNIT_Q14 && dot_s3 >= -UNIT_Q14,
		"dot product outside the unit range")

endmodule

@@ rtl/core/phong_vertex_lighting.sv @@
// Phong vertex lighting.
// vtx: one vertex per transaction: normal N and triangle center C, Q12.12, plus
//      an end-of-mesh flag. res: one transaction per vertex with the diffuse and
//      specular terms in Q1.14 and the flag copied to mesh_done, in input order.
// cfg: writes the light vector L (index 0, 1, 2 for x, y, z); other indexes are
//      dropped. Write only while no vertex is in flight. cfg.ready is always high.
// From vtx to res a vertex goes through two passes of a 48-stage normalizer
// (26 square root stages and 16 divider stages, one bit each), a 3-stage dot
// product after each, and a 2-stage reflection in between. A vertex can enter
// every cycle while res is not stalled, so throughput is one vertex per clock.
// When res is not taken, the whole pipeline holds and vtx.ready drops until the
// waiting result leaves; nothing is lost or repeated.
// Reset clears all valid bits and sets L to (0, 0, 1.0).
module phong_vertex_lighting (
	input logic      clk,
	input logic      arst_n,
	pvl_vtx_if.sink  vtx,
	pvl_res_if.source res,
	pvl_cfg_if.sink  cfg
);
	import pvl_pkg::*;

	`include "assert_macros.svh"

	fld_t light_q [3];
	logic en;

	vin_t l_vin [3];
	vin_t n_vin [3];
	q14_t l_u [3];
	q14_t n_u [3];
	logic l_v, n_v;
	q14_t dif;
	logic dif_v;

	fld_t n_dl [DLY_NL][3];
	fld_t l_dl [DLY_NL][3];
	fld_t c_dl [DLY_C][3];
	q14_t dif_dl [DLY_DIF];
	logic end_dl [DLY_END];

	logic signed [PW-1:0] p_s1 [3];
	fld_t                 l_s1 [3];
	logic                 v_s1;
	vin_t                 r_s2 [3];
	logic                 v_s2;

	vin_t v_vin [3];
	q14_t v_u [3];
	q14_t r_u [3];
	logic vn_v, rn_v;
	q14_t spec;
	logic spec_v;

	vin_t r_c [3];

	assign en = !res.valid || res.ready;
	assign vtx.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q[0] <= LIGHT_X_RST;
			light_q[1] <= LIGHT_Y_RST;
			light_q[2] <= LIGHT_Z_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LIGHT_X: light_q[0] <= cfg.data;
				REG_LIGHT_Y: light_q[1] <= cfg.data;
				REG_LIGHT_Z: light_q[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		fld_t n_in [3];
		n_in[0] = vtx.normal_x;
		n_in[1] = vtx.normal_y;
		n_in[2] = vtx.normal_z;
		for (int i = 0; i < 3; i++) begin
			l_vin[i] = {{(VW-FW){light_q[i][FW-1]}}, light_q[i]};
			n_vin[i] = {{(VW-FW){n_in[i][FW-1]}}, n_in[i]};
		end
	end

	pvl_norm u_norm_l (.clk, .arst_n, .en, .in_valid(vtx.valid), .vin(l_vin),
		.out_valid(l_v), .u(l_u));
	pvl_norm u_norm_n (.clk, .arst_n, .en, .in_valid(vtx.valid), .vin(n_vin),
		.out_valid(n_v), .u(n_u));
	pvl_dot u_dot_dif (.clk, .arst_n, .en, .in_valid(l_v && n_v), .a(l_u), .b(n_u),
		.out_valid(dif_v), .dot(dif));

	// side data travels alongside the normalizers
	always_ff @(posedge clk) begin
		if (en) begin
			n_dl[0][0] <= vtx.normal_x;
			n_dl[0][1] <= vtx.normal_y;
			n_dl[0][2] <= vtx.normal_z;
			c_dl[0][0] <= vtx.center_x;
			c_dl[0][1] <= vtx.center_y;
			c_dl[0][2] <= vtx.center_z;
			for (int i = 0; i < 3; i++) l_dl[0][i] <= light_q[i];
			for (int k = 1; k < DLY_NL; k++) begin
				n_dl[k] <= n_dl[k-1];
				l_dl[k] <= l_dl[k-1];
			end
			for (int k = 1; k < DLY_C; k++) c_dl[k] <= c_dl[k-1];
			end_dl[0] <= vtx.end_of_mesh;
			for (int k = 1; k < DLY_END; k++) end_dl[k] <= end_dl[k-1];
			dif_dl[0] <= dif;
			for (int k = 1; k < DLY_DIF; k++) dif_dl[k] <= dif_dl[k-1];
		end
	end

	// reflection R = 2 * round(N * diffuse) - L
	always_comb begin
		logic [PW-1:0] pm;
		logic [VW-1:0] pr;
		logic signed [VW:0] rs;
		for (int i = 0; i < 3; i++) begin
			pm = p_s1[i][PW-1] ? (~p_s1[i] + 1'b1) : p_s1[i];
			pr = VW'((pm + PW'(HALF_Q14)) >> 14);
			rs = p_s1[i][PW-1] ? -$signed({1'b0, pr}) : $signed({1'b0, pr});
			r_c[i] = VW'((rs <<< 1) - (VW+1)'(l_s1[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= dif_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i] <= n_dl[DLY_NL-1][i] * dif;
				l_s1[i] <= l_dl[DLY_NL-1][i];
				r_s2[i] <= r_c[i];
			end
		end
	end

	always_comb begin
		vin_t ce;
		for (int i = 0; i < 3; i++) begin
			ce = {{(VW-FW){c_dl[DLY_C-1][i][FW-1]}}, c_dl[DLY_C-1][i]};
			v_vin[i] = -ce;
		end
	end

	pvl_norm u_norm_v (.clk, .arst_n, .en, .in_valid(v_s2), .vin(v_vin),
		.out_valid(vn_v), .u(v_u));
	pvl_norm u_norm_r (.clk, .arst_n, .en, .in_valid(v_s2), .vin(r_s2),
		.out_valid(rn_v), .u(r_u));
	pvl_dot u_dot_spec (.clk, .arst_n, .en, .in_valid(vn_v && rn_v), .a(v_u), .b(r_u),
		.out_valid(spec_v), .dot(spec));

	assign res.valid         = spec_v;
	assign res.specular_term = spec;
	assign res.diffuse_term  = dif_dl[DLY_DIF-1];
	assign res.mesh_done     = end_dl[DLY_END-1];

	`ASSERT_AT(a_stall_hold, (res.valid && !res.ready) |=> (res.valid &&
		$stable(res.diffuse_term) && $stable(res.specular_term) &&
		$stable(res.mesh_done)), "stalled result changed")

endmodule
